[sv/pss_pkg.sv]
package pss_pkg;

   localparam int CoordW = 24;
   localparam int DistW = 49;

   // Operation codes carried in the mode field.
   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_MOVE = 2'd1;
   localparam logic [1:0] MODE_EVAL = 2'd2;
   // The remaining code leaves the table untouched and reports the row.
   localparam logic [1:0] MODE_NOP = 2'd3;

   // Configuration register indexes.
   localparam logic [2:0] REG_GOAL_X = 3'd0;
   localparam logic [2:0] REG_GOAL_Y = 3'd1;
   localparam logic [2:0] REG_INERTIA = 3'd2;
   localparam logic [2:0] REG_GAIN_OWN = 3'd3;
   localparam logic [2:0] REG_GAIN_GRP = 3'd4;
   localparam logic [2:0] REG_LIMIT = 3'd5;

   localparam logic [DistW-1:0] DIST_ALL_ONES = {DistW{1'b1}};

   typedef struct packed {
      logic [1:0] mode;
      logic [5:0] slot;
      logic signed [23:0] load_x;
      logic signed [23:0] load_y;
      logic [15:0] rand_one;
      logic [15:0] rand_two;
   } req_type;

   typedef struct packed {
      logic signed [23:0] pos_x_out;
      logic signed [23:0] pos_y_out;
      logic signed [23:0] vel_x_out;
      logic signed [23:0] vel_y_out;
      logic signed [23:0] leader_x;
      logic signed [23:0] leader_y;
      logic own_improved;
      logic group_improved;
   } rsp_type;

   // One particle table row.
   typedef struct packed {
      logic signed [23:0] px;
      logic signed [23:0] py;
      logic signed [23:0] vx;
      logic signed [23:0] vy;
      logic signed [23:0] bx;
      logic signed [23:0] by;
      logic [DistW-1:0] bd;
   } row_type;

   localparam int RowW = $bits(row_type);

   // Configuration values seen by the execution unit.
   typedef struct packed {
      logic signed [23:0] goal_x;
      logic signed [23:0] goal_y;
      logic [15:0] inertia;
      logic [15:0] gain_own;
      logic [15:0] gain_grp;
      logic [22:0] limit;
   } cfg_type;

   // Saturate a 26-bit signed sum to the coordinate range.
   function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
      logic signed [23:0] r;
      if (v > 26'sd8388607) r = 24'sh7fffff;
      else if (v < -26'sd8388608) r = 24'sh800000;
      else r = v[23:0];
      return r;
   endfunction

endpackage

[sv/pss_ram.sv]
module pss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

[sv/pss_front.sv]
module pss_front #(
   parameter int PARTICLES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pss_pkg::req_type  req_data,
   input  logic              exe_take,
   output logic              q_valid,
   output pss_pkg::req_type  q_data,
   output logic              q_in_range
);
   import pss_pkg::*;

   localparam int Depth = 2;

   // Two-entry queue of accepted commands, classified by slot range.
   req_type q_ff [Depth];
   logic rng_ff [Depth];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push;

   // At most one command waits here while the back executes the one before it.
   assign busy = (cnt_ff != 2'd0);
   assign push = start && !busy;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data = q_ff[rp_ff];
   assign q_in_range = rng_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff ^ push;
      rp_in = rp_ff ^ exe_take;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, exe_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= req_data;
         rng_ff[wp_ff] <= ({26'd0, req_data.slot} < 32'(PARTICLES));
      end
   end

endmodule

[sv/pss_exec.sv]
module pss_exec #(
   parameter int PARTICLES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  pss_pkg::cfg_type  cfg,
   input  logic              q_valid,
   input  pss_pkg::req_type  q_data,
   input  logic              q_in_range,
   output logic              exe_take,
   output logic              rsp_valid,
   output pss_pkg::rsp_type  rsp_data
);
   import pss_pkg::*;

   localparam int AW = $clog2(PARTICLES);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_MUL = 3'd2;
   localparam logic [2:0] ST_SUM = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] st_ff, st_in;
   req_type cmd_ff;
   logic rng_ff;
   row_type rd_row, wr_row;
   logic wr_en;
   logic [AW-1:0] rd_addr;

   logic signed [23:0] gbx_ff, gby_ff;
   logic [DistW-1:0] gbd_ff;

   // Products: x axis then y axis, registered before the sum.
   logic signed [41:0] pi_x_ff, pi_y_ff;
   logic signed [57:0] po_x_ff, po_y_ff, pg_x_ff, pg_y_ff;
   logic [32:0] kg1_ff, kg2_ff;
   logic [48:0] dsq_ff;
   logic signed [23:0] nvx_ff, nvy_ff;
   rsp_type out_ff;
   logic out_v_ff;

   // The row address follows the queue head until the command is taken,
   // then stays on the command being executed.
   assign rd_addr = (st_ff == ST_IDLE) ? AW'(q_data.slot) : AW'(cmd_ff.slot);

   pss_ram #(.WIDTH(RowW), .DEPTH(PARTICLES)) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(AW'(cmd_ff.slot)),
      .wr_data(wr_row),
      .rd_addr(rd_addr),
      .rd_data(rd_row)
   );

   assign exe_take = (st_ff == ST_IDLE) && q_valid;
   assign rsp_valid = out_v_ff;
   assign rsp_data = out_ff;

   // Rounded, clamped velocity from the 2^-28 sum.
   function automatic logic signed [23:0] vel_round(
      input logic signed [41:0] pi, input logic signed [57:0] po,
      input logic signed [57:0] pg, input logic [22:0] lim);
      logic signed [63:0] acc;
      logic signed [35:0] q;
      logic signed [35:0] l;
      logic signed [23:0] r;
      acc = ($signed({{22{pi[41]}}, pi}) <<< 16) + 64'(po) + 64'(pg)
            + 64'sd134217728;
      q = acc[63:28];
      l = $signed({13'd0, lim});
      if (q > l) r = lim;
      else if (q < -l) r = -$signed({1'b0, lim});
      else r = q[23:0];
      return r;
   endfunction

   logic signed [24:0] dx, dy;
   logic signed [49:0] dx2, dy2;
   logic signed [24:0] ex_x, ex_y, eg_x, eg_y;
   logic signed [23:0] sx, sy;

   always_comb begin
      // Source position: load data or stored row.
      sx = (cmd_ff.mode == MODE_LOAD) ? cmd_ff.load_x : rd_row.px;
      sy = (cmd_ff.mode == MODE_LOAD) ? cmd_ff.load_y : rd_row.py;
      dx = 25'(sx) - 25'(cfg.goal_x);
      dy = 25'(sy) - 25'(cfg.goal_y);
      dx2 = dx * dx;
      dy2 = dy * dy;
      ex_x = 25'(rd_row.bx) - 25'(rd_row.px);
      ex_y = 25'(rd_row.by) - 25'(rd_row.py);
      eg_x = 25'(gbx_ff) - 25'(rd_row.px);
      eg_y = 25'(gby_ff) - 25'(rd_row.py);
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (q_valid) st_in = ST_READ;
         ST_READ: st_in = ST_MUL;
         ST_MUL: st_in = ST_SUM;
         ST_SUM: st_in = ST_DONE;
         ST_DONE: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else st_ff <= st_in;
   end

   always_ff @(posedge clock) begin
      if (exe_take) begin
         cmd_ff <= q_data;
         rng_ff <= q_in_range;
      end
      // Combined random factor and gain, one multiply ahead of the products.
      if (st_ff == ST_READ) begin
         kg1_ff <= (17'(cmd_ff.rand_one) + 17'd65536) * cfg.gain_own;
         kg2_ff <= (17'(cmd_ff.rand_two) + 17'd65536) * cfg.gain_grp;
      end
      if (st_ff == ST_MUL) begin
         pi_x_ff <= $signed({1'b0, cfg.inertia}) * rd_row.vx;
         pi_y_ff <= $signed({1'b0, cfg.inertia}) * rd_row.vy;
         po_x_ff <= $signed({1'b0, kg1_ff}) * ex_x;
         po_y_ff <= $signed({1'b0, kg1_ff}) * ex_y;
         pg_x_ff <= $signed({1'b0, kg2_ff}) * eg_x;
         pg_y_ff <= $signed({1'b0, kg2_ff}) * eg_y;
         dsq_ff <= dx2[48:0] + dy2[48:0];
      end
      if (st_ff == ST_SUM) begin
         nvx_ff <= vel_round(pi_x_ff, po_x_ff, pg_x_ff, cfg.limit);
         nvy_ff <= vel_round(pi_y_ff, po_y_ff, pg_y_ff, cfg.limit);
      end
   end

   // Write-back row and result for the finishing command.
   logic g_upd, o_upd;
   always_comb begin
      wr_row = rd_row;
      wr_en = 1'b0;
      g_upd = 1'b0;
      o_upd = 1'b0;
      if (st_ff == ST_DONE && rng_ff) begin
         unique case (cmd_ff.mode)
            MODE_LOAD: begin
               wr_row = '{px: cmd_ff.load_x, py: cmd_ff.load_y, vx: 24'sd0,
                          vy: 24'sd0, bx: cmd_ff.load_x, by: cmd_ff.load_y,
                          bd: dsq_ff};
               wr_en = 1'b1;
               g_upd = (cmd_ff.slot == 6'd0);
            end
            MODE_MOVE: begin
               wr_row.vx = nvx_ff;
               wr_row.vy = nvy_ff;
               wr_row.px = sat24(26'(rd_row.px) + 26'(nvx_ff));
               wr_row.py = sat24(26'(rd_row.py) + 26'(nvy_ff));
               wr_en = 1'b1;
            end
            MODE_EVAL: begin
               g_upd = (dsq_ff < gbd_ff);
               o_upd = (dsq_ff < rd_row.bd);
               if (o_upd) begin
                  wr_row.bx = rd_row.px;
                  wr_row.by = rd_row.py;
                  wr_row.bd = dsq_ff;
               end
               wr_en = o_upd;
            end
            default: wr_en = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gbx_ff <= '0;
         gby_ff <= '0;
         gbd_ff <= DIST_ALL_ONES;
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= (st_ff == ST_DONE);
         if (g_upd) begin
            gbx_ff <= wr_row.px;
            gby_ff <= wr_row.py;
            gbd_ff <= dsq_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == ST_DONE) begin
         out_ff.pos_x_out <= rng_ff ? wr_row.px : '0;
         out_ff.pos_y_out <= rng_ff ? wr_row.py : '0;
         out_ff.vel_x_out <= rng_ff ? wr_row.vx : '0;
         out_ff.vel_y_out <= rng_ff ? wr_row.vy : '0;
         out_ff.leader_x <= g_upd ? wr_row.px : gbx_ff;
         out_ff.leader_y <= g_upd ? wr_row.py : gby_ff;
         out_ff.own_improved <= o_upd;
         out_ff.group_improved <= g_upd && (cmd_ff.mode == MODE_EVAL);
      end
   end

endmodule

[sv/particle_swarm_step_2d.sv]
// Two-dimensional particle swarm engine over a table of PARTICLES particles.
// Command channel: a command transfers when start is high and busy is low.
// mode selects load, move, evaluate or no-op; slot picks the particle.
// Result channel: rsp_valid marks one cycle carrying the result; the
// receiver cannot stall it, so it must take the result in that cycle.
// Configuration: csr_we writes csr_data to register csr_index; the user must
// write only while no command is outstanding, which the block does not enforce.
// The back takes one command at a time through the table read-modify-write
// and the product stage. busy drops once the back takes the command, so one
// more command can wait in the queue while the back is working.
// The front queues the command, the back reads the row, forms the products,
// sums and rounds them, writes back any updated row and emits the result.
// Reset clears control state, the group best and the registers to their
// defaults; particle rows hold nothing until loaded.
module particle_swarm_step_2d #(
   parameter int PARTICLES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pss_pkg::req_type req_data,
   output logic             rsp_valid,
   output pss_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [23:0]      csr_data
);
   import pss_pkg::*;

   cfg_type cfg_ff;
   logic q_valid, q_in_range, exe_take;
   req_type q_data;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{goal_x: 24'sd0, goal_y: 24'sd0, inertia: 16'd4096,
                     gain_own: 16'd2048, gain_grp: 16'd2048, limit: 23'd128000};
      end else if (csr_we) begin
         unique case (csr_index)
            REG_GOAL_X: cfg_ff.goal_x <= csr_data;
            REG_GOAL_Y: cfg_ff.goal_y <= csr_data;
            REG_INERTIA: cfg_ff.inertia <= csr_data[15:0];
            REG_GAIN_OWN: cfg_ff.gain_own <= csr_data[15:0];
            REG_GAIN_GRP: cfg_ff.gain_grp <= csr_data[15:0];
            REG_LIMIT: cfg_ff.limit <= csr_data[22:0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   pss_front #(.PARTICLES(PARTICLES)) u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .exe_take(exe_take), .q_valid(q_valid),
      .q_data(q_data), .q_in_range(q_in_range)
   );

   pss_exec #(.PARTICLES(PARTICLES)) u_exec (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .q_valid(q_valid),
      .q_data(q_data), .q_in_range(q_in_range), .exe_take(exe_take),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   // A result strobe is never held high.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");

   // An accepted command makes the block busy next cycle.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised");

   // The block only turns busy because a command was presented.
   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy without command");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import pss_pkg::*;

   localparam int NumSlots = 64;
   localparam longint CycleLimit = 400000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_we;
   logic [2:0] csr_index;
   logic [23:0] csr_data;

   particle_swarm_step_2d dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Predicted particle table, group best and register copies.
   logic signed [23:0] tab_px[NumSlots], tab_py[NumSlots];
   logic signed [23:0] tab_vx[NumSlots], tab_vy[NumSlots];
   logic signed [23:0] tab_bx[NumSlots], tab_by[NumSlots];
   logic [48:0] tab_bd[NumSlots];
   bit loaded[NumSlots];
   logic signed [23:0] lead_x, lead_y;
   logic [48:0] lead_d;
   logic signed [23:0] goal_x, goal_y;
   logic [15:0] inertia, gain_own, gain_grp;
   logic [22:0] limit;

   req_type pending_cmds[$];
   rsp_type expected_rsps[$];
   int errors = 0;
   int gap = 0;
   longint cycles = 0;

   function automatic logic [48:0] dist_sq(logic signed [23:0] x, logic signed [23:0] y);
      longint dx, dy;
      dx = longint'(x) - longint'(goal_x);
      dy = longint'(y) - longint'(goal_y);
      return 49'(dx * dx + dy * dy);
   endfunction

   function automatic logic signed [23:0] new_speed(logic signed [23:0] v,
         logic signed [23:0] p, logic signed [23:0] pb, logic signed [23:0] gb,
         logic [15:0] r1, logic [15:0] r2);
      longint k1, k2, acc, q, lim;
      k1 = (65536 + longint'(r1)) * longint'(gain_own);
      k2 = (65536 + longint'(r2)) * longint'(gain_grp);
      lim = longint'(limit);
      acc = longint'(inertia) * longint'(v) * 65536;
      acc += k1 * (longint'(pb) - longint'(p));
      acc += k2 * (longint'(gb) - longint'(p));
      acc += longint'(1) << 27;
      q = acc >>> 28;
      if (q > lim) q = lim;
      if (q < -lim) q = -lim;
      return 24'(q);
   endfunction

   function automatic logic signed [23:0] clip24(longint v);
      if (v > 8388607) return 24'sh7fffff;
      if (v < -8388608) return 24'sh800000;
      return 24'(v);
   endfunction

   // Advance the predicted state for one command and return its result.
   function automatic rsp_type swarm_step(req_type c);
      rsp_type r;
      int s;
      logic [48:0] d;
      logic signed [23:0] nvx, nvy;
      r = '0;
      s = c.slot;
      if (c.mode == MODE_LOAD) begin
         d = dist_sq(c.load_x, c.load_y);
         tab_px[s] = c.load_x; tab_py[s] = c.load_y;
         tab_vx[s] = '0; tab_vy[s] = '0;
         tab_bx[s] = c.load_x; tab_by[s] = c.load_y; tab_bd[s] = d;
         loaded[s] = 1;
         if (s == 0) begin
            lead_x = c.load_x; lead_y = c.load_y; lead_d = d;
         end
      end else if (c.mode == MODE_MOVE) begin
         nvx = new_speed(tab_vx[s], tab_px[s], tab_bx[s], lead_x, c.rand_one, c.rand_two);
         nvy = new_speed(tab_vy[s], tab_py[s], tab_by[s], lead_y, c.rand_one, c.rand_two);
         tab_vx[s] = nvx; tab_vy[s] = nvy;
         tab_px[s] = clip24(longint'(tab_px[s]) + longint'(nvx));
         tab_py[s] = clip24(longint'(tab_py[s]) + longint'(nvy));
      end else if (c.mode == MODE_EVAL) begin
         d = dist_sq(tab_px[s], tab_py[s]);
         if (d < lead_d) begin
            lead_x = tab_px[s]; lead_y = tab_py[s]; lead_d = d;
            r.group_improved = 1;
         end
         if (d < tab_bd[s]) begin
            tab_bx[s] = tab_px[s]; tab_by[s] = tab_py[s]; tab_bd[s] = d;
            r.own_improved = 1;
         end
      end
      r.pos_x_out = tab_px[s]; r.pos_y_out = tab_py[s];
      r.vel_x_out = tab_vx[s]; r.vel_y_out = tab_vy[s];
      r.leader_x = lead_x; r.leader_y = lead_y;
      return r;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // Append a command to the pending list.
   function automatic void add_cmd(req_type c);
      pending_cmds.insert(pending_cmds.size(), c);
   endfunction

   // Command driver: a transfer happens at an edge with start high and busy low.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         // hold the command until it transfers
      end else if (gap > 0) begin
         gap <= gap - 1;
         start <= 1'b0;
      end else if (pending_cmds.size() > 0 && !(start && !busy && pending_cmds.size() == 0)) begin
         req_type c;
         c = pending_cmds.pop_front();
         expected_rsps.insert(expected_rsps.size(), swarm_step(c));
         req_data <= c;
         start <= 1'b1;
         gap <= pick_gap();
      end else begin
         start <= 1'b0;
      end
   end

   // Result monitor: every strobe carries one transfer.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = expected_rsps.pop_front();
            if (e !== rsp_data) begin
               $display("%0t: result mismatch: expected %h actual %h", $time, e, rsp_data);
               errors++;
            end
         end
      end
      if (cycles > CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [23:0] val);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_GOAL_X: goal_x = val;
         REG_GOAL_Y: goal_y = val;
         REG_INERTIA: inertia = val[15:0];
         REG_GAIN_OWN: gain_own = val[15:0];
         REG_GAIN_GRP: gain_grp = val[15:0];
         REG_LIMIT: limit = val[22:0];
         default: ;
      endcase
   endtask

   // Wait for the queue and the block to drain before any register write.
   task automatic drain();
      while (pending_cmds.size() > 0 || expected_rsps.size() > 0 || start || busy)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic req_type make_cmd(logic [1:0] m, int s);
      req_type c;
      c.mode = m;
      c.slot = 6'(s);
      c.load_x = 24'($urandom);
      c.load_y = 24'($urandom);
      c.rand_one = 16'($urandom);
      c.rand_two = 16'($urandom);
      return c;
   endfunction

   // Queue a random mix; move and evaluate only address loaded slots.
   task automatic random_phase(int count, int span);
      req_type c;
      int s, k;
      for (k = 0; k < count; k++) begin
         s = $urandom_range(0, span - 1);
         if (!loaded[s] || $urandom_range(0, 9) == 0) begin
            c = make_cmd(MODE_LOAD, s);
            if ($urandom_range(0, 3) == 0)
               c.load_x = goal_x + 24'($urandom_range(0, 2000)) - 24'd1000;
            if ($urandom_range(0, 3) == 0)
               c.load_y = goal_y + 24'($urandom_range(0, 2000)) - 24'd1000;
         end else if ($urandom_range(0, 12) == 0) begin
            c = make_cmd(MODE_NOP, s);
         end else begin
            c = make_cmd($urandom_range(0, 1) ? MODE_MOVE : MODE_EVAL, s);
         end
         add_cmd(c);
      end
   endtask

   initial begin
      req_type c;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      goal_x = 0; goal_y = 0;
      inertia = 4096; gain_own = 2048; gain_grp = 2048; limit = 128000;
      lead_x = 0; lead_y = 0; lead_d = DIST_ALL_ONES;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, every mode, ties and the no-op mode.
      c = make_cmd(MODE_LOAD, 0); c.load_x = 24'sh7fffff; c.load_y = 24'sh800000;
      add_cmd(c);
      c = make_cmd(MODE_LOAD, 63); c.load_x = 24'sh800000; c.load_y = 24'sh7fffff;
      add_cmd(c);
      c = make_cmd(MODE_MOVE, 63); c.rand_one = 16'hffff; c.rand_two = 16'hffff;
      add_cmd(c);
      c = make_cmd(MODE_MOVE, 63); c.rand_one = 0; c.rand_two = 0;
      add_cmd(c);
      c = make_cmd(MODE_EVAL, 63); add_cmd(c);
      c = make_cmd(MODE_EVAL, 63); add_cmd(c);
      c = make_cmd(MODE_EVAL, 0); add_cmd(c);
      c = make_cmd(MODE_NOP, 0); add_cmd(c);
      c = make_cmd(MODE_LOAD, 5); c.load_x = 0; c.load_y = 0; add_cmd(c);
      c = make_cmd(MODE_EVAL, 5); add_cmd(c);
      c = make_cmd(MODE_EVAL, 5); add_cmd(c);
      drain();

      // Extreme register settings.
      write_reg(REG_INERTIA, 24'hffff);
      write_reg(REG_GAIN_OWN, 24'hffff);
      write_reg(REG_GAIN_GRP, 24'hffff);
      write_reg(REG_LIMIT, 24'h7fffff);
      write_reg(REG_GOAL_X, 24'h7fffff);
      write_reg(REG_GOAL_Y, 24'h800000);
      random_phase(300, 8);
      drain();
      write_reg(REG_LIMIT, 24'h0);
      write_reg(REG_INERTIA, 24'h0);
      write_reg(REG_GAIN_OWN, 24'h0);
      write_reg(REG_GAIN_GRP, 24'h0);
      random_phase(150, 64);
      drain();

      // Random settings across several phases.
      repeat (5) begin
         write_reg(REG_GOAL_X, 24'($urandom));
         write_reg(REG_GOAL_Y, 24'($urandom));
         write_reg(REG_INERTIA, 24'($urandom_range(0, 8192)));
         write_reg(REG_GAIN_OWN, 24'($urandom_range(0, 65535)));
         write_reg(REG_GAIN_GRP, 24'($urandom_range(0, 65535)));
         write_reg(REG_LIMIT, 24'($urandom_range(0, 8388607)));
         random_phase(310, $urandom_range(0, 1) ? 4 : 64);
         drain();
      end

      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/pss_pkg.sv
sv/pss_ram.sv
sv/pss_front.sv
sv/pss_exec.sv
sv/particle_swarm_step_2d.sv
tb/tb_top.sv
